FILE: hdl/pfrl_pkg.sv
// Shared types and constants for the page frame replacement list.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package pfrl_pkg;

    // list geometry
    localparam int MAX_FRAMES   = 64;
    localparam int PAGE_BITS    = 10;
    localparam int IDX_BITS     = $clog2(MAX_FRAMES);

    // port field widths
    localparam int CFG_W        = 7;
    localparam int FRAME_OUT_W  = 6;
    localparam int PAGE_OUT_W   = 10;
    localparam int VICTIM_W     = 6;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(64);

    // command codes
    localparam logic CMD_FIFO   = 1'b0;
    localparam logic CMD_RANDOM = 1'b1;

    // one list entry: physical frame, resident page, occupied flag
    typedef struct packed {
        logic [IDX_BITS-1:0]  frame;
        logic [PAGE_BITS-1:0] page;
        logic                 valid;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/page_frame_replacement_list.sv
// Page frame replacement list: FIFO and random victim selection over one list memory.
// Depends on pfrl_pkg.
//
// Usage:
//   Requests enter on start with command, fault_page and victim_index; one is
//   taken at a clock edge where start is high and busy is low. Exactly one
//   result follows: chosen_frame, evicted_page and write_back are shown for a
//   single cycle with done high. The receiver cannot stall, so the result is
//   taken in that cycle; busy is low again in the same cycle, so a new request
//   may be taken while the result is shown.
//   frames_in_use is written over cfg_valid/cfg_ready; cfg_ready is high while
//   the block is idle.
//   The list memory has a single read port and reads one entry per cycle; with
//   last = clamped frames_in_use - 1:
//     FIFO: scan from position 0 and fill the first free entry in place.
//     random at position p: shift entries p+1..last forward, p's frame to last.
//     FIFO on a full list: scan, then rotate as random at position 0.
//   Reset: frames_in_use returns to 64, every list position reads as its own
//   frame, empty; per-position written flags cover that, no clearing pass.
`default_nettype none

module page_frame_replacement_list (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // fault requests
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              command,
    input  wire logic [pfrl_pkg::PAGE_OUT_W-1:0]   fault_page,
    input  wire logic [pfrl_pkg::VICTIM_W-1:0]     victim_index,
    // results
    output logic                                   done,
    output logic [pfrl_pkg::FRAME_OUT_W-1:0]       chosen_frame,
    output logic [pfrl_pkg::PAGE_OUT_W-1:0]        evicted_page,
    output logic                                   write_back,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pfrl_pkg::CFG_W-1:0]        frames_in_use
);
    import pfrl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;

    // list memory and its per-position written flags
    entry_t                 frame_mem [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]  init_reg;

    logic [2:0]             state_reg,   state_next;
    logic [CFG_W-1:0]       frames_reg;
    logic [PAGE_BITS-1:0]   page_reg,    page_next;
    logic [IDX_BITS-1:0]    last_reg,    last_next;
    entry_t                 old_reg,     old_next;
    logic [IDX_BITS-1:0]    rd_addr_reg;
    logic                   rd_init_reg;
    entry_t                 rd_data_reg;
    logic                   done_reg,    done_next;
    logic [FRAME_OUT_W-1:0] chosen_reg,  chosen_next;
    logic [PAGE_OUT_W-1:0]  evicted_reg, evicted_next;
    logic                   wb_reg,      wb_next;

    logic                   rd_en;
    logic [IDX_BITS-1:0]    rd_addr;
    logic                   wr_en;
    logic [IDX_BITS-1:0]    wr_addr;
    entry_t                 wr_data;
    entry_t                 entry_rd;
    logic [IDX_BITS-1:0]    active_last;
    logic [IDX_BITS-1:0]    victim_pos;

    // handshake outputs
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign done         = done_reg;
    assign chosen_frame = chosen_reg;
    assign evicted_page = evicted_reg;
    assign write_back   = wb_reg;

    // last active position, frames_in_use clamped to 1..MAX_FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            active_last = '0;
        end
        else if (int'(frames_reg) > MAX_FRAMES)
        begin
            active_last = IDX_BITS'(MAX_FRAMES - 1);
        end
        else
        begin
            active_last = IDX_BITS'(frames_reg - CFG_W'(1));
        end
    end

    // victim index clamped to the last active position
    always_comb
    begin
        if (int'(victim_index) > int'(active_last))
        begin
            victim_pos = active_last;
        end
        else
        begin
            victim_pos = IDX_BITS'(victim_index);
        end
    end

    // read data, a never-written position reads as its reset value
    always_comb
    begin
        if (rd_init_reg)
        begin
            entry_rd = rd_data_reg;
        end
        else
        begin
            entry_rd.frame = rd_addr_reg;
            entry_rd.page  = '0;
            entry_rd.valid = 1'b0;
        end
    end

    // sequencer: FIFO scan for a free entry, read-shift-write rotation for random requests and a full list
    always_comb
    begin
        state_next   = state_reg;
        page_next    = page_reg;
        last_next    = last_reg;
        old_next     = old_reg;
        done_next    = 1'b0;
        chosen_next  = chosen_reg;
        evicted_next = evicted_reg;
        wb_next      = wb_reg;
        rd_en        = 1'b0;
        rd_addr      = rd_addr_reg;
        wr_en        = 1'b0;
        wr_addr      = last_reg;
        wr_data      = old_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    page_next = PAGE_BITS'(fault_page);
                    last_next = active_last;
                    rd_en     = 1'b1;
                    if (command == CMD_FIFO)
                    begin
                        rd_addr    = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        rd_addr    = victim_pos;
                        state_next = S_HEAD;
                    end
                end
            end

            S_SCAN:
            begin
                if (!entry_rd.valid)
                begin
                    // free entry, fill in place
                    wr_en         = 1'b1;
                    wr_addr       = rd_addr_reg;
                    wr_data.frame = entry_rd.frame;
                    wr_data.page  = page_reg;
                    wr_data.valid = 1'b1;
                    chosen_next   = FRAME_OUT_W'(entry_rd.frame);
                    evicted_next  = '0;
                    wb_next       = 1'b0;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (rd_addr_reg == last_reg)
                begin
                    // list full, evict the head
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_HEAD;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_addr_reg + IDX_BITS'(1);
                end
            end

            S_HEAD:
            begin
                old_next = entry_rd;
                if (rd_addr_reg == last_reg)
                begin
                    // removed entry already sits at the tail
                    wr_en         = 1'b1;
                    wr_addr       = last_reg;
                    wr_data.frame = entry_rd.frame;
                    wr_data.page  = page_reg;
                    wr_data.valid = 1'b1;
                    chosen_next   = FRAME_OUT_W'(entry_rd.frame);
                    evicted_next  = entry_rd.valid ? PAGE_OUT_W'(entry_rd.page) : '0;
                    wb_next       = entry_rd.valid;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = rd_addr_reg + IDX_BITS'(1);
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // move the entry read last cycle one position forward
                wr_en   = 1'b1;
                wr_addr = rd_addr_reg - IDX_BITS'(1);
                wr_data = entry_rd;
                if (rd_addr_reg == last_reg)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_addr_reg + IDX_BITS'(1);
                end
            end

            S_TAIL:
            begin
                wr_en         = 1'b1;
                wr_addr       = last_reg;
                wr_data.frame = old_reg.frame;
                wr_data.page  = page_reg;
                wr_data.valid = 1'b1;
                chosen_next   = FRAME_OUT_W'(old_reg.frame);
                evicted_next  = old_reg.valid ? PAGE_OUT_W'(old_reg.page) : '0;
                wb_next       = old_reg.valid;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // list memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
            rd_init_reg <= init_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        page_reg    <= page_next;
        last_reg    <= last_next;
        old_reg     <= old_next;
        chosen_reg  <= chosen_next;
        evicted_reg <= evicted_next;
        wb_reg      <= wb_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            frames_reg <= FRAMES_RESET;
            init_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                frames_reg <= frames_in_use;
            end
            if (wr_en)
            begin
                init_reg[wr_addr] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pfrl_checker.sv
// Port-level checker for page_frame_replacement_list, bound to the top level.
// Depends on pfrl_pkg.
`default_nettype none

module pfrl_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic                              done,
    input  wire logic [pfrl_pkg::PAGE_OUT_W-1:0]   evicted_page,
    input  wire logic                              write_back,
    input  wire logic                              cfg_ready
);
    import pfrl_pkg::*;

    // a taken request always makes the block busy in the cycle after
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // a result shows exactly when the work of a request ends
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done == $fell(busy))
        else $error("result strobe not aligned with end of request");

    // results are single-cycle and never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    // no eviction reported means no page shown
    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !write_back) |-> (evicted_page == '0))
        else $error("evicted page without write back");

    // configuration is taken only while idle
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !busy)
        else $error("configuration ready while busy");

endmodule

bind page_frame_replacement_list pfrl_checker u_pfrl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .evicted_page (evicted_page),
    .write_back   (write_back),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
